// ----- rtl/alist_pkg.sv -----
`timescale 1ns / 1ps

package alist_pkg;

	localparam int DATA_W    = 32;
	localparam int POS_W     = 5;
	localparam int DEPTH_DEF = 32;
	// Cells per leaf of the registered search tree.
	localparam int GRP       = 16;
	localparam int GRP_W     = 4;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_FIND   = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_RANGE     = 2'd2
	} status_t;

	typedef struct packed {
		op_t                       opcode;
		logic signed [DATA_W-1:0]  value;
		logic        [POS_W-1:0]   position;
	} cmd_t;

	typedef struct packed {
		status_t                   status;
		logic        [POS_W-1:0]   found_index;
		logic signed [DATA_W-1:0]  read_value;
	} rsp_t;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic                vld;
		op_t                 op;
		logic [POS_W-1:0]    pos;
		logic [DATA_W-1:0]   value;
	} cell_cmd_t;

endpackage

// ----- rtl/alist_cell.sv -----
`timescale 1ns / 1ps

module alist_cell #(
	parameter int INDEX = 0,
	parameter int DEPTH = alist_pkg::DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  alist_pkg::cell_cmd_t             upd,
	input  alist_pkg::cell_cmd_t             qry,
	input  logic [alist_pkg::DATA_W-1:0]     left_in,
	input  logic [alist_pkg::DATA_W-1:0]     right_in,
	output logic [alist_pkg::DATA_W-1:0]     entry,
	output logic                             match,
	output logic [alist_pkg::DATA_W-1:0]     sel_data
);

	localparam logic [31:0] IDX32   = 32'(INDEX);
	localparam bit          IS_LAST = (INDEX == DEPTH - 1);

	logic [alist_pkg::DATA_W-1:0] entry_q;
	logic [31:0]                  upd_pos;
	logic [31:0]                  qry_pos;

	assign upd_pos = 32'(upd.pos);
	assign qry_pos = 32'(qry.pos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (upd.vld) begin
			unique case (upd.op)
				alist_pkg::OP_INSERT: begin
					if (IDX32 == upd_pos)
						entry_q <= upd.value;
					else if (IDX32 > upd_pos)
						entry_q <= left_in;
				end
				alist_pkg::OP_REMOVE: begin
					// last entry keeps its old value
					if (!IS_LAST && IDX32 >= upd_pos)
						entry_q <= right_in;
				end
				alist_pkg::OP_FIND,
				alist_pkg::OP_READ: ;
				default: ;
			endcase
		end
	end

	assign entry    = entry_q;
	assign match    = qry.vld && (qry.op == alist_pkg::OP_FIND) && (entry_q == qry.value);
	assign sel_data = (qry.vld && (qry.op == alist_pkg::OP_READ) && (IDX32 == qry_pos))
	                  ? entry_q : '0;

endmodule

// ----- rtl/alist_grp.sv -----
`timescale 1ns / 1ps

module alist_grp (
	input  logic                                              clk,
	input  logic [alist_pkg::GRP-1:0]                         match,
	input  logic [alist_pkg::GRP-1:0][alist_pkg::DATA_W-1:0]  data,
	output logic                                              hit_s2,
	output logic [alist_pkg::GRP_W-1:0]                       loc_s2,
	output logic [alist_pkg::DATA_W-1:0]                      data_s2
);

	logic                          hit;
	logic [alist_pkg::GRP_W-1:0]   loc;
	logic [alist_pkg::DATA_W-1:0]  rd;

	// lowest matching cell wins
	always_comb begin
		hit = 1'b0;
		loc = '0;
		rd  = '0;
		for (int i = alist_pkg::GRP - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit = 1'b1;
				loc = alist_pkg::GRP_W'(i);
			end
			rd = rd | data[i];
		end
	end

	always_ff @(posedge clk) begin
		hit_s2  <= hit;
		loc_s2  <= loc;
		data_s2 <= rd;
	end

endmodule

// ----- rtl/array_list_insert_remove_find_core.sv -----
`timescale 1ns / 1ps

// Channel | Direction | Handshake              | Payload
// --------+-----------+------------------------+---------------------------------
// cmd     | in        | cmd_valid / cmd_stall  | alist_pkg::cmd_t (opcode, value, position)
// rsp     | out       | rsp_valid / rsp_stall  | alist_pkg::rsp_t (status, found_index, read_value)
//
// A transaction runs in order: the accept edge updates the chain of cells,
// the cells compare and groups of 16 are reduced into the group registers,
// the lowest group is picked into the output register, and the response is taken.
// One transaction is in flight at a time; cmd_stall is high until the
// response is taken. The response register holds while rsp_stall is high.
// Reset clears every entry to zero and empties the pipeline at once.

module array_list_insert_remove_find_core #(
	parameter int DEPTH = alist_pkg::DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  alist_pkg::cmd_t   cmd,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output alist_pkg::rsp_t   rsp
);

	localparam int NG     = (DEPTH + alist_pkg::GRP - 1) / alist_pkg::GRP;
	localparam int NG_W   = (NG > 1) ? $clog2(NG) : 1;
	localparam int FULL_W = NG_W + alist_pkg::GRP_W;
	localparam int PAD    = NG * alist_pkg::GRP;

	// ---------------------------------------------------------------------
	// Accept and stage 1: command held for the compare cycle
	// ---------------------------------------------------------------------
	logic                  accept;
	logic                  v_s1;
	logic                  v_s2;
	logic                  rsp_valid_q;
	alist_pkg::cell_cmd_t  upd;
	alist_pkg::cell_cmd_t  cmd_s1;
	logic                  range_ok_s1;
	alist_pkg::op_t        op_s2;
	logic                  range_ok_s2;
	alist_pkg::rsp_t       rsp_q;
	logic                  in_range;

	// Hold off new commands while anything is in flight.
	assign cmd_stall = v_s1 | v_s2 | rsp_valid_q;
	assign accept    = cmd_valid & ~cmd_stall;
	assign in_range  = (32'(cmd.position) < 32'(DEPTH));

	// Table updates happen at the accept edge; out-of-range positions drop.
	assign upd.vld   = accept & in_range;
	assign upd.op    = cmd.opcode;
	assign upd.pos   = cmd.position;
	assign upd.value = cmd.value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.vld   <= 1'b1;
			cmd_s1.op    <= cmd.opcode;
			cmd_s1.pos   <= cmd.position;
			cmd_s1.value <= cmd.value;
			range_ok_s1  <= in_range;
		end else begin
			cmd_s1.vld   <= 1'b0;
		end
	end

	// ---------------------------------------------------------------------
	// Chain of cells: each holds one entry and shifts to its neighbors
	// ---------------------------------------------------------------------
	logic [DEPTH-1:0][alist_pkg::DATA_W-1:0]     entries;
	logic [PAD-1:0]                              match_pad;
	logic [PAD-1:0][alist_pkg::DATA_W-1:0]       data_pad;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [alist_pkg::DATA_W-1:0] left_n;
		logic [alist_pkg::DATA_W-1:0] right_n;

		// End cells never take from a missing neighbor; tie to own entry.
		if (i == 0) begin : g_first
			assign left_n = entries[i];
		end else begin : g_mid_l
			assign left_n = entries[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_n = entries[i];
		end else begin : g_mid_r
			assign right_n = entries[i+1];
		end

		alist_cell #(
			.INDEX (i),
			.DEPTH (DEPTH)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.upd      (upd),
			.qry      (cmd_s1),
			.left_in  (left_n),
			.right_in (right_n),
			.entry    (entries[i]),
			.match    (match_pad[i]),
			.sel_data (data_pad[i])
		);
	end

	// Pad the last group with empty slots.
	for (genvar i = DEPTH; i < PAD; i++) begin : g_pad
		assign match_pad[i] = 1'b0;
		assign data_pad[i]  = '0;
	end

	// ---------------------------------------------------------------------
	// Stage 2: per-group lowest match and read data
	// ---------------------------------------------------------------------
	logic [NG-1:0]                               grp_hit_s2;
	logic [NG-1:0][alist_pkg::GRP_W-1:0]         grp_loc_s2;
	logic [NG-1:0][alist_pkg::DATA_W-1:0]        grp_data_s2;

	for (genvar g = 0; g < NG; g++) begin : g_grp
		alist_grp u_grp (
			.clk     (clk),
			.match   (match_pad[g*alist_pkg::GRP +: alist_pkg::GRP]),
			.data    (data_pad[g*alist_pkg::GRP +: alist_pkg::GRP]),
			.hit_s2  (grp_hit_s2[g]),
			.loc_s2  (grp_loc_s2[g]),
			.data_s2 (grp_data_s2[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		op_s2       <= cmd_s1.op;
		range_ok_s2 <= range_ok_s1;
	end

	// ---------------------------------------------------------------------
	// Output stage: pick the lowest group and build the response
	// ---------------------------------------------------------------------
	logic                           any_hit;
	logic [NG_W-1:0]                gsel;
	logic [alist_pkg::GRP_W-1:0]    lsel;
	logic [FULL_W-1:0]              full_idx;
	logic [alist_pkg::DATA_W-1:0]   rd_all;
	alist_pkg::rsp_t                rsp_d;

	always_comb begin
		any_hit = 1'b0;
		gsel    = '0;
		lsel    = '0;
		rd_all  = '0;
		for (int g = NG - 1; g >= 0; g--) begin
			if (grp_hit_s2[g]) begin
				any_hit = 1'b1;
				gsel    = NG_W'(g);
				lsel    = grp_loc_s2[g];
			end
			rd_all = rd_all | grp_data_s2[g];
		end
		full_idx = {gsel, lsel};

		rsp_d.status      = alist_pkg::ST_OK;
		rsp_d.found_index = '0;
		rsp_d.read_value  = '0;
		priority if (op_s2 == alist_pkg::OP_FIND) begin
			// a wide table reports the match index modulo 32
			if (any_hit)
				rsp_d.found_index = alist_pkg::POS_W'(full_idx);
			else
				rsp_d.status = alist_pkg::ST_NOT_FOUND;
		end else if (!range_ok_s2) begin
			rsp_d.status = alist_pkg::ST_RANGE;
		end else if (op_s2 == alist_pkg::OP_READ) begin
			rsp_d.read_value = rd_all;
		end else begin
			rsp_d.status = alist_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (v_s2) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_valid_q && !rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Load the response once; hold it while stalled.
	always_ff @(posedge clk) begin
		if (v_s2)
			rsp_q <= rsp_d;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// ---------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({v_s1, v_s2, rsp_valid_q}))
		else $error("more than one transaction in flight");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##3 rsp_valid)
		else $error("response did not appear three cycles after accept");

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == alist_pkg::ST_NOT_FOUND)
		|-> (rsp.found_index == '0 && rsp.read_value == '0))
		else $error("not-found response carries nonzero fields");

	a_no_range_full: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && DEPTH >= 32) |-> (rsp.status != alist_pkg::ST_RANGE))
		else $error("range error reported although every position is valid");

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import alist_pkg::*;

	localparam int LIST_DEPTH  = DEPTH_DEF;
	localparam int PHASE_ITEMS = 150;
	localparam int HOLD_CYCLES = 60;
	localparam int DRAIN_WAIT  = 8;
	// Slowest legal run: ~625 transactions, each with a capped sender gap,
	// a few receiver stalls and the pass through the block, plus two hold-offs.
	localparam int CYCLE_LIMIT = 400000;

	// Sender idle and receiver stall odds (percent) for each random phase.
	localparam int PHASE_IDLE  [4] = '{0, 77, 0, 15};
	localparam int PHASE_STALL [4] = '{0, 0, 77, 15};

	typedef struct {
		cmd_t c;
		bit   typed;
		rsp_t want;
	} list_row_t;

	logic  clk;
	logic  arst_n;
	logic  cmd_valid;
	logic  cmd_stall;
	cmd_t  cmd;
	logic  rsp_valid;
	logic  rsp_stall;
	rsp_t  rsp;

	// Sideband that travels with the offered transaction: a hand-typed response.
	logic  row_typed;
	rsp_t  row_want;

	logic [DATA_W-1:0] list_shadow [LIST_DEPTH];
	rsp_t              awaited_rsps [$];
	int                mismatch_count;
	int                cycle_count;
	int                send_idle_pct;
	int                stall_pct;
	bit                squeeze_req;

	array_list_insert_remove_find_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hold reset low at the start, then release it for good.
	initial begin
		arst_n <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Apply one operation to the shadow list and return the response it gives.
	function automatic rsp_t apply_list_op(input cmd_t c);
		rsp_t r;
		int   i;
		int   pos;
		bit   hit;
		r   = '0;
		pos = int'(c.position);
		hit = 1'b0;
		r.status = ST_OK;
		if (c.opcode == OP_FIND) begin
			for (i = 0; i < LIST_DEPTH && !hit; i++) begin
				if (list_shadow[i] == c.value) begin
					hit = 1'b1;
					r.found_index = i[POS_W-1:0];
				end
			end
			if (!hit)
				r.status = ST_NOT_FOUND;
		end else if (pos >= LIST_DEPTH) begin
			r.status = ST_RANGE;
		end else begin
			case (c.opcode)
				OP_INSERT: begin
					// Shift the tail up by one; the last entry falls off.
					for (i = LIST_DEPTH - 1; i > pos; i--)
						list_shadow[i] = list_shadow[i-1];
					list_shadow[pos] = c.value;
				end
				OP_REMOVE: begin
					// Shift the tail down by one; the last entry keeps its value.
					for (i = pos; i < LIST_DEPTH - 1; i++)
						list_shadow[i] = list_shadow[i+1];
				end
				default: r.read_value = list_shadow[pos];
			endcase
		end
		return r;
	endfunction

	// Draw a random operation; bias values toward ones already in the list
	// so that finds hit, and toward a few small values so duplicates pile up.
	function automatic cmd_t rand_list_cmd();
		cmd_t c;
		int   pick;
		pick = $urandom_range(99);
		if (pick < 35)
			c.opcode = OP_INSERT;
		else if (pick < 55)
			c.opcode = OP_REMOVE;
		else if (pick < 80)
			c.opcode = OP_FIND;
		else
			c.opcode = OP_READ;
		pick = $urandom_range(99);
		if (pick < 8)
			c.position = '0;
		else if (pick < 16)
			c.position = POS_W'(LIST_DEPTH - 1);
		else
			c.position = POS_W'($urandom_range(LIST_DEPTH - 1));
		pick = $urandom_range(99);
		if (pick < 40) begin
			c.value = list_shadow[$urandom_range(LIST_DEPTH - 1)];
		end else if (pick < 55) begin
			c.value = DATA_W'($urandom_range(7));
		end else if (pick < 65) begin
			case ($urandom_range(3))
				0:       c.value = '0;
				1:       c.value = '1;
				2:       c.value = 32'h8000_0000;
				default: c.value = 32'h7fff_ffff;
			endcase
		end else begin
			c.value = $urandom;
		end
		return c;
	endfunction

	function automatic list_row_t mk_row(input op_t op, input logic [DATA_W-1:0] v,
			input logic [POS_W-1:0] p, input bit typed, input status_t st,
			input logic [POS_W-1:0] idx, input logic [DATA_W-1:0] rd);
		list_row_t row;
		row.c.opcode            = op;
		row.c.value             = v;
		row.c.position          = p;
		row.typed               = typed;
		row.want.status         = st;
		row.want.found_index    = idx;
		row.want.read_value     = rd;
		return row;
	endfunction

	// Offer one transaction after a random idle gap and hold it until taken.
	task automatic offer(input cmd_t c, input bit typed, input rsp_t want);
		int gap;
		gap = 0;
		while (gap < 64 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		row_typed <= typed;
		row_want  <= want;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
	endtask

	// Stimulus: directed rows first, then four random phases.
	initial begin : stim
		list_row_t rows [$];
		int        ph;
		int        n;
		cmd_valid      <= 1'b0;
		cmd            <= '0;
		row_typed      <= 1'b0;
		row_want       <= '0;
		send_idle_pct   = 0;
		stall_pct       = 0;
		squeeze_req     = 1'b0;
		mismatch_count  = 0;
		foreach (list_shadow[i])
			list_shadow[i] = '0;

		// Fresh table reads back zero everywhere; find ignores position.
		rows.push_back(mk_row(OP_READ,   32'h0,         5'd0,  1, ST_OK, 5'd0, 32'h0));
		rows.push_back(mk_row(OP_READ,   32'hffff_ffff, 5'd31, 1, ST_OK, 5'd0, 32'h0));
		rows.push_back(mk_row(OP_FIND,   32'h0,         5'd17, 1, ST_OK, 5'd0, 32'h0));
		rows.push_back(mk_row(OP_FIND,   32'h7fff_ffff, 5'd0,  1, ST_NOT_FOUND, 5'd0, 32'h0));
		rows.push_back(mk_row(OP_FIND,   32'h8000_0000, 5'd31, 1, ST_NOT_FOUND, 5'd0, 32'h0));
		// Extremes at both ends; insert at the last index only overwrites it.
		rows.push_back(mk_row(OP_INSERT, 32'h8000_0000, 5'd0,  1, ST_OK, 5'd0, 32'h0));
		rows.push_back(mk_row(OP_INSERT, 32'h7fff_ffff, 5'd31, 1, ST_OK, 5'd0, 32'h0));
		rows.push_back(mk_row(OP_READ,   32'h0,         5'd0,  1, ST_OK, 5'd0, 32'h8000_0000));
		rows.push_back(mk_row(OP_READ,   32'h0,         5'd31, 1, ST_OK, 5'd0, 32'h7fff_ffff));
		rows.push_back(mk_row(OP_READ,   32'h0,         5'd1,  1, ST_OK, 5'd0, 32'h0));
		rows.push_back(mk_row(OP_FIND,   32'h7fff_ffff, 5'd0,  0, ST_OK, 5'd0, 32'h0));
		// Remove at the last index changes nothing but still reports ok.
		rows.push_back(mk_row(OP_REMOVE, 32'h0,         5'd31, 1, ST_OK, 5'd0, 32'h0));
		rows.push_back(mk_row(OP_READ,   32'h0,         5'd31, 0, ST_OK, 5'd0, 32'h0));
		rows.push_back(mk_row(OP_INSERT, 32'hffff_ffff, 5'd5,  0, ST_OK, 5'd0, 32'h0));
		rows.push_back(mk_row(OP_FIND,   32'hffff_ffff, 5'd9,  0, ST_OK, 5'd0, 32'h0));
		rows.push_back(mk_row(OP_FIND,   32'h0,         5'd0,  0, ST_OK, 5'd0, 32'h0));
		rows.push_back(mk_row(OP_REMOVE, 32'h1234_5678, 5'd0,  0, ST_OK, 5'd0, 32'h0));
		rows.push_back(mk_row(OP_READ,   32'h0,         5'd0,  0, ST_OK, 5'd0, 32'h0));
		// Alternating bit patterns in value and position.
		rows.push_back(mk_row(OP_INSERT, 32'h5555_5555, 5'd21, 0, ST_OK, 5'd0, 32'h0));
		rows.push_back(mk_row(OP_INSERT, 32'haaaa_aaaa, 5'd10, 0, ST_OK, 5'd0, 32'h0));
		rows.push_back(mk_row(OP_READ,   32'h0,         5'd21, 0, ST_OK, 5'd0, 32'h0));
		rows.push_back(mk_row(OP_READ,   32'h0,         5'd10, 0, ST_OK, 5'd0, 32'h0));
		rows.push_back(mk_row(OP_REMOVE, 32'h0,         5'd5,  0, ST_OK, 5'd0, 32'h0));
		rows.push_back(mk_row(OP_FIND,   32'h5555_5555, 5'd0,  0, ST_OK, 5'd0, 32'h0));
		rows.push_back(mk_row(OP_FIND,   32'haaaa_aaaa, 5'd31, 0, ST_OK, 5'd0, 32'h0));

		@(posedge clk);
		while (!arst_n)
			@(posedge clk);

		foreach (rows[i])
			offer(rows[i].c, rows[i].typed, rows[i].want);

		// Random phases; the first and last open with a long receiver hold-off
		// while transactions keep coming, so the block backs up into cmd_stall.
		for (ph = 0; ph < 4; ph++) begin
			send_idle_pct = PHASE_IDLE[ph];
			stall_pct     = PHASE_STALL[ph];
			if (ph == 0 || ph == 3)
				squeeze_req = 1'b1;
			for (n = 0; n < PHASE_ITEMS; n++)
				offer(rand_list_cmd(), 1'b0, '0);
		end

		// Drop valid, step past the last accept edge so its response is queued,
		// drain outstanding responses, then let the pipe settle.
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (awaited_rsps.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Receiver: random stalls per phase, or a counted hold-off on request.
	initial begin : rsp_sink
		int hold;
		hold = 0;
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (squeeze_req) begin
				squeeze_req = 1'b0;
				hold = HOLD_CYCLES;
			end
			if (hold > 0) begin
				hold--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// On each accepted command, advance the shadow list and queue the response.
	always @(posedge clk) begin : cmd_watch
		rsp_t predicted;
		if (arst_n && cmd_valid && !cmd_stall) begin
			predicted = apply_list_op(cmd);
			// Prefer the hand-typed response where the row carries one.
			if (row_typed)
				awaited_rsps.push_back(row_want);
			else
				awaited_rsps.push_back(predicted);
		end
	end

	// Compare each taken response with the oldest awaited one, field by field.
	always @(posedge clk) begin : rsp_check
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (awaited_rsps.size() == 0) begin
				$error("unexpected response: status %0d, found_index %0d, read_value %0d",
					rsp.status, rsp.found_index, rsp.read_value);
				mismatch_count++;
			end else begin
				want = awaited_rsps.pop_front();
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp.status);
					mismatch_count++;
				end
				if (rsp.found_index !== want.found_index) begin
					$error("found_index: expected %0d, got %0d",
						want.found_index, rsp.found_index);
					mismatch_count++;
				end
				if (rsp.read_value !== want.read_value) begin
					$error("read_value: expected %0d, got %0d",
						want.read_value, rsp.read_value);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog: end the run if it drags far past the slowest correct pace.
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

endmodule
